### rtl/core/ascii85_stream_decoder_top_macros.svh
// Assertion helpers for the Ascii85 decoder. The module using them must
// have clk_i and rst_ni in scope.
`ifndef ASCII85_STREAM_DECODER_TOP_MACROS_SVH
`define ASCII85_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle property.
`define A85_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent now, consequent in the next cycle.
`define A85_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/a85_pkg.sv
package a85_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MULT_W      = 20;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [MULT_W-1:0] RADIX = MULT_W'(85);

  typedef enum logic [2:0] {
    PH_LT    = 3'd0,
    PH_TILDE = 3'd1,
    PH_BODY  = 3'd2,
    PH_GT    = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_START   = 3'd1,
    ST_BAD_CHAR    = 3'd2,
    ST_MISSING_END = 3'd3,
    ST_TRAILING    = 3'd4
  } status_e;

  // One queued job: nbytes data bytes of word (MSB first), then an optional
  // status-only result. The final result of a job carries last.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        tail;
    status_e     status;
  } job_t;

  // Padding a group of n digits with 'u' (84) k = 5-n times equals
  // w*85^k + 85^k - 1.
  function automatic logic [MULT_W-1:0] pad_mult(input logic [2:0] cnt);
    logic [MULT_W-1:0] m;
    begin
      case (cnt)
        3'd2:    m = MULT_W'(614125);
        3'd3:    m = MULT_W'(7225);
        3'd4:    m = MULT_W'(85);
        default: m = MULT_W'(1);
      endcase
      return m;
    end
  endfunction

endpackage

### rtl/core/a85_front.sv
`include "ascii85_stream_decoder_top_macros.svh"

module a85_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_char_i,
  input  logic            end_of_input_i,
  output logic            in_ready_o,
  input  logic            full_i,
  output logic            push_o,
  output a85_pkg::job_t   job_o
);

  a85_pkg::phase_e phase_q, phase_d, phase_nxt;
  logic [31:0] group_q, group_d;
  logic [2:0]  count_q, count_d;
  logic        err_q, err_d;

  logic        fire;
  logic        is_space, is_digit;
  logic [7:0]  digit8;
  logic        bad, flush, zero_word, digit_en, word_done;
  a85_pkg::status_e bad_st;

  logic [a85_pkg::MULT_W-1:0] mult, addend;
  logic [31:0] prod;
  logic [31:0] mac;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;

  assign is_space = (in_char_i == a85_pkg::CH_SP) || (in_char_i == a85_pkg::CH_TAB) ||
                    (in_char_i == a85_pkg::CH_CR) || (in_char_i == a85_pkg::CH_LF);
  assign is_digit = (in_char_i >= a85_pkg::CH_BANG) && (in_char_i <= a85_pkg::CH_U);
  assign digit8   = in_char_i - a85_pkg::CH_BANG;

  // Shared multiply-add: digit accumulate or end-of-stream padding.
  always_comb begin
    if (end_of_input_i) begin
      mult   = a85_pkg::pad_mult(count_q);
      addend = mult - a85_pkg::MULT_W'(1);
    end else begin
      mult   = a85_pkg::RADIX;
      addend = {{(a85_pkg::MULT_W-7){1'b0}}, digit8[6:0]};
    end
  end

  // 32 x 20 product, kept modulo 2^32.
  assign prod = group_q * {{(32-a85_pkg::MULT_W){1'b0}}, mult};
  assign mac  = prod + {{(32-a85_pkg::MULT_W){1'b0}}, addend};

  // Classify the character against the framing state.
  always_comb begin
    bad       = 1'b0;
    bad_st    = a85_pkg::ST_OK;
    flush     = 1'b0;
    zero_word = 1'b0;
    digit_en  = 1'b0;
    phase_nxt = phase_q;
    if (!err_q) begin
      if (end_of_input_i) begin
        unique case (phase_q) inside
          a85_pkg::PH_LT, a85_pkg::PH_TILDE: begin
            bad    = 1'b1;
            bad_st = a85_pkg::ST_BAD_START;
          end
          a85_pkg::PH_BODY, a85_pkg::PH_GT: begin
            bad    = 1'b1;
            bad_st = a85_pkg::ST_MISSING_END;
          end
          default: begin
            flush     = 1'b1;
            phase_nxt = a85_pkg::PH_LT;
          end
        endcase
      end else if (!is_space) begin
        unique case (phase_q)
          a85_pkg::PH_LT: begin
            if (in_char_i == a85_pkg::CH_LT) begin
              phase_nxt = a85_pkg::PH_TILDE;
            end else begin
              bad    = 1'b1;
              bad_st = a85_pkg::ST_BAD_START;
            end
          end
          a85_pkg::PH_TILDE: begin
            if (in_char_i == a85_pkg::CH_TILDE) begin
              phase_nxt = a85_pkg::PH_BODY;
            end else begin
              bad    = 1'b1;
              bad_st = a85_pkg::ST_BAD_START;
            end
          end
          a85_pkg::PH_BODY: begin
            if (in_char_i == a85_pkg::CH_TILDE) begin
              phase_nxt = a85_pkg::PH_GT;
            end else if (in_char_i == a85_pkg::CH_Z && count_q == 3'd0) begin
              zero_word = 1'b1;
            end else if (is_digit) begin
              digit_en = 1'b1;
            end else begin
              bad    = 1'b1;
              bad_st = a85_pkg::ST_BAD_CHAR;
            end
          end
          a85_pkg::PH_GT: begin
            if (in_char_i == a85_pkg::CH_GT) begin
              phase_nxt = a85_pkg::PH_DONE;
            end else begin
              bad    = 1'b1;
              bad_st = a85_pkg::ST_BAD_CHAR;
            end
          end
          default: begin
            bad    = 1'b1;
            bad_st = a85_pkg::ST_TRAILING;
          end
        endcase
      end
    end
  end

  assign word_done = digit_en && (count_q == 3'd4);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    group_d = group_q;
    count_d = count_q;
    err_d   = err_q;
    if (fire) begin
      phase_d = phase_nxt;
      if (bad) begin
        err_d = 1'b1;
      end
      if (flush || word_done) begin
        group_d = '0;
        count_d = '0;
      end else if (digit_en) begin
        group_d = mac;
        count_d = count_q + 3'd1;
      end
    end
  end

  // Job toward the back end.
  always_comb begin
    push_o        = fire && (bad || flush || zero_word || word_done);
    job_o.word    = '0;
    job_o.nbytes  = '0;
    job_o.tail    = 1'b1;
    job_o.status  = a85_pkg::ST_OK;
    if (bad) begin
      job_o.status = bad_st;
    end else if (flush) begin
      job_o.word   = mac;
      job_o.nbytes = (count_q >= 3'd2) ? count_q - 3'd1 : 3'd0;
    end else if (zero_word || word_done) begin
      job_o.word   = zero_word ? 32'd0 : mac;
      job_o.nbytes = 3'd4;
      job_o.tail   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= a85_pkg::PH_LT;
      group_q <= '0;
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      group_q <= group_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  `A85_ASSERT_NEXT(a_err_sticky, err_q, err_q, "error flag cleared without reset")
  `A85_ASSERT(a_no_job_after_err, err_q |-> !push_o, "job issued after error")

endmodule

### rtl/core/a85_fifo.sv
`include "ascii85_stream_decoder_top_macros.svh"

module a85_fifo #(
  parameter int unsigned Depth = a85_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  a85_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output a85_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  a85_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `A85_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `A85_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")

endmodule

### rtl/core/a85_back.sv
`include "ascii85_stream_decoder_top_macros.svh"

module a85_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  a85_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    data_byte_o,
  output logic          is_data_o,
  output logic [2:0]    status_o,
  output logic          last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       isd_q, isd_d;
  a85_pkg::status_e st_q, st_d;
  logic       last_q, last_d;

  logic       load;
  logic [2:0] last_idx;
  logic       final_res;
  logic [7:0] sel_byte;

  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign last_idx  = head_i.nbytes + {2'b0, head_i.tail} - 3'd1;
  assign final_res = ({1'b0, idx_q} == last_idx);
  assign pop_o     = load && final_res;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.word[31:24];
      2'd1:    sel_byte = head_i.word[23:16];
      2'd2:    sel_byte = head_i.word[15:8];
      default: sel_byte = head_i.word[7:0];
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = final_res ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    isd_d  = ({1'b0, idx_q} < head_i.nbytes);
    byte_d = isd_d ? sel_byte : 8'd0;
    st_d   = isd_d ? a85_pkg::ST_OK : head_i.status;
    last_d = final_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      isd_q  <= isd_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign data_byte_o = byte_q;
  assign is_data_o   = isd_q;
  assign status_o    = st_q;
  assign last_o      = last_q;

  `A85_ASSERT(a_status_is_last, (valid_q && !isd_q) |-> last_q,
    "status-only result not marked last")
  `A85_ASSERT(a_data_ok, (valid_q && isd_q) |-> (st_q == a85_pkg::ST_OK),
    "data result with nonzero status")

endmodule

### rtl/core/ascii85_stream_decoder_top.sv
// Ascii85 stream decoder, one text character per transaction.
// Throughput: one character per cycle while the job queue has room; 'z' runs
// or output stalls fill it. Output drains one result per cycle while the receiver
// is ready (four bytes per word). A job goes into the job queue, then into
// the output register behind out_valid_o; queued jobs add wait.
// Reset (rst_ni low, async): framing awaits '<', group and error cleared.
module ascii85_stream_decoder_top #(
  parameter int unsigned QueueDepth = a85_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input character stream
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  // decoded result stream
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       is_data_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  // Front end: framing state machine plus the base-85 accumulator. Each
  // accepted character produces at most one job: a full word (four bytes),
  // a status report, or the end-of-stream flush (padded bytes + status).
  // It only stalls when the job queue is full.
  logic          push, full, pop, empty;
  a85_pkg::job_t push_job, head_job;

  a85_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .in_ready_o     (in_ready_o),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // Job queue: lets characters keep flowing while a word is being
  // serialized, and lets the back end stall on out_ready_i on its own.
  a85_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_job)
  );

  // Back end: walks the head job into the output register one result per cycle
  // unless out_ready_i stalls; the job pops when its last result is loaded.
  a85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .is_data_o   (is_data_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import a85_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 11;
  // Cycles with no transaction on either side before the run is declared hung.
  // Far above the slowest legal case: the longest sender gap plus four results
  // each waiting out a long receiver stall.
  localparam int IDLE_LIMIT  = 2000;
  // Drain time after the last expected result, with slack.
  localparam int DRAIN_TICKS = 16;
  localparam int RANDOM_CHARS = 380;

  // One input character (or end-of-input marker) waiting to be sent.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  // One decoded result as the block should present it.
  typedef struct {
    logic [7:0] data;
    logic       is_data;
    status_e    status;
    logic       last;
  } a85_result_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i      = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] data_byte_o;
  logic       is_data_o;
  logic [2:0] status_o;
  logic       last_o;

  ascii85_stream_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .is_data_o     (is_data_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Characters still to be sent, and results the decoder still owes us.
  char_item_t  char_q[$];
  a85_result_t decoded_q[$];

  // Shadow of the decoder's state.
  logic [31:0] grp_word;
  logic [2:0]  grp_digits;
  phase_e      frame_ph;
  logic        err_latched;

  int    err_count;
  int    chars_sent;
  int    frames_built;
  int    bytes_checked;
  int    reports_checked;
  string closing_case;

  function automatic logic is_ws(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void push_result(logic [7:0] data, logic isd, status_e st,
                                      logic lst);
    a85_result_t r;
    r.data    = data;
    r.is_data = isd;
    r.status  = st;
    r.last    = lst;
    decoded_q.push_back(r);
  endfunction

  // Status-only result; any non-OK status freezes the decoder until reset.
  function automatic void flag_status(status_e st);
    push_result(8'h00, 1'b0, st, 1'b1);
    if (st != ST_OK) err_latched = 1'b1;
  endfunction

  function automatic void emit_word(logic [31:0] w);
    for (int i = 0; i < 4; i++)
      push_result(w[31 - 8 * i -: 8], 1'b1, ST_OK, i == 3);
  endfunction

  // Advance the shadow decoder by one accepted character and queue what it
  // should produce.
  function automatic void decode_char(logic [7:0] c, logic eoi);
    logic [31:0] w;
    if (err_latched) return;
    if (eoi) begin
      if (frame_ph == PH_LT || frame_ph == PH_TILDE) begin
        flag_status(ST_BAD_START);
      end else if (frame_ph != PH_DONE) begin
        flag_status(ST_MISSING_END);
      end else begin
        // pad a short group with 'u' digits; a lone digit yields nothing
        if (grp_digits >= 3'd2 && grp_digits <= 3'd4) begin
          w = grp_word;
          for (int d = grp_digits; d < 5; d++) w = w * 32'd85 + 32'd84;
          for (int d = 0; d + 1 < grp_digits; d++)
            push_result(w[31 - 8 * d -: 8], 1'b1, ST_OK, 1'b0);
        end
        flag_status(ST_OK);
        grp_word   = '0;
        grp_digits = '0;
        frame_ph   = PH_LT;
      end
      return;
    end
    if (is_ws(c)) return;
    case (frame_ph)
      PH_LT: begin
        if (c != CH_LT) flag_status(ST_BAD_START);
        else frame_ph = PH_TILDE;
      end
      PH_TILDE: begin
        if (c != CH_TILDE) flag_status(ST_BAD_START);
        else frame_ph = PH_BODY;
      end
      PH_BODY: begin
        if (c == CH_TILDE) begin
          frame_ph = PH_GT;
        end else if (c == CH_Z) begin
          if (grp_digits != 0) flag_status(ST_BAD_CHAR);
          else emit_word(32'h0);
        end else if (c < CH_BANG || c > CH_U) begin
          flag_status(ST_BAD_CHAR);
        end else begin
          grp_word   = grp_word * 32'd85 + 32'(c - CH_BANG);
          grp_digits = grp_digits + 3'd1;
          if (grp_digits == 3'd5) begin
            emit_word(grp_word);
            grp_word   = '0;
            grp_digits = '0;
          end
        end
      end
      PH_GT: begin
        if (c != CH_GT) flag_status(ST_BAD_CHAR);
        else frame_ph = PH_DONE;
      end
      default: flag_status(ST_TRAILING);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c);
    char_item_t it;
    it.ch  = c;
    it.eoi = 1'b0;
    char_q.push_back(it);
  endfunction

  // End of input carries a random, ignored character so all in_char bits toggle.
  function automatic void add_eoi();
    char_item_t it;
    it.ch  = 8'($urandom_range(0, 255));
    it.eoi = 1'b1;
    char_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic void maybe_ws();
    if ($urandom_range(0, 7) == 0) add_char(rand_ws());
  endfunction

  // Digits biased toward the ends of the range.
  function automatic logic [7:0] rand_digit();
    case ($urandom_range(0, 9))
      0:       return CH_BANG;
      1:       return CH_U;
      default: return 8'($urandom_range(33, 117));
    endcase
  endfunction

  // Random non-whitespace character other than the one given.
  function automatic logic [7:0] rand_char_except(logic [7:0] allowed);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_ws(c) || c == allowed);
    return c;
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) begin
      add_char(rand_digit());
      maybe_ws();
    end
  endfunction

  // A complete well-formed stream with random groups and a random partial tail.
  function automatic void add_frame();
    maybe_ws();
    add_char(CH_LT);
    maybe_ws();
    add_char(CH_TILDE);
    maybe_ws();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0:       add_char(CH_Z);
        1:       repeat (5) add_char(CH_U);   // wraps past 2^32
        default: add_digits(5);
      endcase
    end
    add_digits($urandom_range(0, 4));
    add_char(CH_TILDE);
    maybe_ws();
    add_char(CH_GT);
    maybe_ws();
    add_eoi();
    frames_built++;
  endfunction

  // Open a stream and leave some digits pending in the body.
  function automatic void add_open_body(int ndig);
    add_char(CH_LT);
    add_char(CH_TILDE);
    add_digits(ndig);
  endfunction

  // Any error freezes the decoder until reset, so exactly one error
  // scenario closes each run; the seed picks which.
  function automatic void add_error_tail();
    logic [7:0] c;
    case ($urandom_range(0, 6))
      0: begin
        closing_case = "bad start character";
        add_char(rand_char_except(CH_LT));
      end
      1: begin
        closing_case = "bad character after opening less-than";
        add_char(CH_LT);
        add_char(rand_char_except(CH_TILDE));
      end
      2: begin
        closing_case = "end of input before body";
        if ($urandom_range(0, 1) == 1) add_char(CH_LT);
        add_eoi();
      end
      3: begin
        add_open_body($urandom_range(1, 4));
        if ($urandom_range(0, 1) == 1) begin
          closing_case = "z inside a group";
          add_char(CH_Z);
        end else begin
          closing_case = "non-digit in body";
          do c = 8'($urandom_range(0, 255));
          while (is_ws(c) || (c >= CH_BANG && c <= CH_U) || c == CH_TILDE || c == CH_Z);
          add_char(c);
        end
      end
      4: begin
        closing_case = "bad character after closing tilde";
        add_open_body($urandom_range(0, 4));
        add_char(CH_TILDE);
        add_char(rand_char_except(CH_GT));
      end
      5: begin
        closing_case = "missing terminator";
        add_open_body($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) add_char(CH_TILDE);
        add_eoi();
      end
      default: begin
        closing_case = "trailing input";
        add_open_body($urandom_range(0, 4));
        add_char(CH_TILDE);
        add_char(CH_GT);
        add_char(rand_char_except(CH_SP));
      end
    endcase
    // Everything after the error must be swallowed silently.
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) add_eoi();
      else add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps; prediction
  // runs on every accepted input transaction.
  // ---------------------------------------------------------------------
  char_item_t nxt_item;
  int         burst_left = 1;
  int         gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      in_char_i      <= 8'h00;
      end_of_input_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_char(in_char_i, end_of_input_i);
        chars_sent++;
      end
      // Slot is free if nothing was held or the held item just went through.
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (char_q.size() > 0) begin
          nxt_item = char_q.pop_front();
          in_valid_i     <= 1'b1;
          in_char_i      <= nxt_item.ch;
          end_of_input_i <= nxt_item.eoi;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver back-pressure: the mode is redrawn periodically from always ready,
  // coin-flip, one-in-four periodic and mostly stalled.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int mode_ticks = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      mode_ticks++;
      if (mode_ticks % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 1);
        2:       out_ready_i <= (mode_ticks % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each output transaction against the oldest expectation.
  // ---------------------------------------------------------------------
  function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      err_count++;
    end
  endfunction

  a85_result_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "actual data %0h is_data %0b status %0d last %0b"},
                 $time, data_byte_o, is_data_o, status_o, last_o);
        err_count++;
      end else begin
        exp_res = decoded_q.pop_front();
        check_field("data_byte", exp_res.data, data_byte_o);
        check_field("is_data", 8'(exp_res.is_data), 8'(is_data_o));
        check_field("status", 8'(exp_res.status), 8'(status_o));
        check_field("last", 8'(exp_res.last), 8'(last_o));
        if (exp_res.is_data) bytes_checked++;
        else reports_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a transaction.
  int idle_ticks = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_ticks = 0;
    else idle_ticks++;
    if (idle_ticks >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, decoded_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: build the stimulus, reset once, run, drain, report.
  // ---------------------------------------------------------------------
  initial begin
    err_count       = 0;
    chars_sent      = 0;
    frames_built    = 0;
    bytes_checked   = 0;
    reports_checked = 0;
    grp_word        = '0;
    grp_digits      = '0;
    frame_ph        = PH_LT;
    err_latched     = 1'b0;

    // Whitespace everywhere, a z group and the all-ones word "s8W-!".
    add_char(CH_SP);
    add_char(CH_LT);
    add_char(CH_TAB);
    add_char(CH_TILDE);
    add_char(CH_Z);
    add_char("s"); add_char("8"); add_char("W"); add_char("-"); add_char(CH_BANG);
    add_char(CH_LF);
    add_char(CH_TILDE);
    add_char(CH_GT);
    add_eoi();
    // Two-digit tail of max digits: padded word overflows and wraps.
    add_char(CH_LT); add_char(CH_TILDE);
    add_char(CH_U); add_char(CH_U);
    add_char(CH_TILDE); add_char(CH_GT);
    add_eoi();
    // A lone leftover digit flushes nothing but the closing report.
    add_char(CH_LT); add_char(CH_TILDE);
    add_char(CH_BANG);
    add_char(CH_TILDE); add_char(CH_GT);
    add_char(CH_CR);
    add_eoi();
    frames_built = 3;

    // Random streams fill the rest of the character budget.
    while (char_q.size() < RANDOM_CHARS) add_frame();
    add_error_tail();

    repeat (RESET_TICKS) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Check at falling edges so the clocked blocks have settled.
    while (char_q.size() > 0 || in_valid_i || decoded_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);

    $display("Sent %0d characters in %0d streams; checked %0d bytes and %0d status reports.",
             chars_sent, frames_built, bytes_checked, reports_checked);
    $display("Run closed with the %s error case.", closing_case);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
